// File: rtl/core/osa_pkg.sv
// osa_pkg: item types, command codes and status codes of the slot allocator
// no dependencies; used by the channel interface users and the top level

package osa_pkg;

	localparam logic [1:0] CMD_ASSIGN  = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_CLEANUP = 2'd2;

	localparam logic [2:0] STS_OK           = 3'd0;
	localparam logic [2:0] STS_NOT_ATTACHED = 3'd1;
	localparam logic [2:0] STS_ALREADY_HOLDS = 3'd2;
	localparam logic [2:0] STS_ALL_BUSY     = 3'd3;
	localparam logic [2:0] STS_NOT_OWNER    = 3'd4;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] owner_id;
		logic       owner_attached;
		logic [4:0] slot_in;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  slot_out;
		logic [31:0] disable_mask;
	} rsp_item_t;

endpackage

// File: rtl/core/osa_chan_if.sv
// osa_chan_if: valid/ready channel carrying one item of type payload_t
// no dependencies; the payload type is given by the instantiating level

interface osa_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/owner_tagged_slot_allocator.sv
// owner_tagged_slot_allocator: round-robin slot allocator with owner tags
// depends on osa_pkg and osa_chan_if
//
// usage:
//   req carries one command item (assign, release, cleanup) per handshake;
//   rsp carries exactly one result item per accepted request, in order.
//   req.ready is high only while the sequencer is idle; one item is worked
//   at a time by a single owner-id comparator walking the owner-id memory.
// steps from accept to result register:
//   assign, attached: owner-id scan over all slots, then, if the owner holds no slot,
//     the free-slot walk from the search pointer
//   cleanup, attached: owner-id scan over all slots
//   release, attached and in range: read of the slot's owner id, then the check
//   any rejected or unused command: straight to the result register
// the next request is taken only once the current result is in the output register
// the walks go one slot per cycle; the scan reads through the single owner-id memory read port
// reset: all slots free (taken flags cleared), search pointer zero; the
//   owner-id memory is not cleared, entries count only when taken.
// stall: the result sits in an output register; a new request is accepted
//   while it waits, and a finished item holds until that register frees.

module owner_tagged_slot_allocator
	import osa_pkg::*;
#(
	parameter int SLOT_COUNT  = 32,
	parameter int OWNER_COUNT = 256
) (
	input  logic clk,
	input  logic arst_n,
	osa_chan_if.sink   req,
	osa_chan_if.source rsp
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SEARCH,
		S_RD,
		S_CHK,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [1:0]            cmd_q;
	logic [7:0]            id_q;
	logic [IW-1:0]         slot_q;
	logic [CW-1:0]         cnt_q;
	logic [IW-1:0]         ptr_q;
	logic [SLOT_COUNT-1:0] taken_q;
	logic                  hold_q;
	logic [2:0]            status_q;
	logic [IW-1:0]         grant_q;
	logic [31:0]           mask_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	logic [7:0]            id_mem [SLOT_COUNT];
	logic [7:0]            rd_data_s1;
	logic [IW-1:0]         cmp_idx_s1;
	logic                  cmp_vld_s1;

	logic [IW-1:0]         rd_addr;
	logic                  wr_en;
	logic                  attached;
	logic                  match;
	logic                  scan_issue;
	req_item_t             req_item;

	function automatic logic [31:0] mask_of(input logic [IW-1:0] idx);
		logic [31:0] m;
		m = '0;
		if (32'(idx) < 32'd32) begin
			m = 32'd1 << idx;
		end
		return m;
	endfunction

	assign req_item   = req.payload;
	assign attached   = req_item.owner_attached && (32'(req_item.owner_id) < OWNER_COUNT);
	assign scan_issue = (state_q == S_SCAN) && (cnt_q != CW'(SLOT_COUNT));
	assign rd_addr    = (state_q == S_SCAN) ? cnt_q[IW-1:0] : slot_q;
	assign match      = taken_q[cmp_idx_s1] && (rd_data_s1 == id_q);
	assign wr_en      = (state_q == S_SEARCH) && (cnt_q != CW'(SLOT_COUNT)) && !taken_q[ptr_q];

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// owner-id memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[ptr_q] <= id_q;
		end
		rd_data_s1 <= id_mem[rd_addr];
		cmp_idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			taken_q     <= '0;
			hold_q      <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= scan_issue;
			if (rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= req_item.command;
						id_q     <= req_item.owner_id;
						slot_q   <= IW'(req_item.slot_in);
						cnt_q    <= '0;
						hold_q   <= 1'b0;
						status_q <= STS_OK;
						grant_q  <= '0;
						mask_q   <= '0;
						priority if (req_item.command == CMD_ASSIGN) begin
							if (!attached) begin
								status_q <= STS_NOT_ATTACHED;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (req_item.command == CMD_RELEASE) begin
							if (!attached) begin
								status_q <= STS_NOT_ATTACHED;
								state_q  <= S_DONE;
							end else if (32'(req_item.slot_in) >= SLOT_COUNT) begin
								status_q <= STS_NOT_OWNER;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_RD;
							end
						end else if (req_item.command == CMD_CLEANUP) begin
							state_q <= attached ? S_SCAN : S_DONE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (cmp_vld_s1 && match) begin
						if (cmd_q == CMD_CLEANUP) begin
							taken_q[cmp_idx_s1] <= 1'b0;
							mask_q              <= mask_q | mask_of(cmp_idx_s1);
						end else begin
							hold_q <= 1'b1;
						end
					end
					if (!scan_issue && !cmp_vld_s1) begin
						cnt_q <= '0;
						if (cmd_q == CMD_CLEANUP) begin
							state_q <= S_DONE;
						end else if (hold_q) begin
							status_q <= STS_ALREADY_HOLDS;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (cnt_q == CW'(SLOT_COUNT)) begin
						status_q <= STS_ALL_BUSY;
						state_q  <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						ptr_q <= (ptr_q == IW'(SLOT_COUNT - 1)) ? '0 : ptr_q + 1'b1;
						if (!taken_q[ptr_q]) begin
							taken_q[ptr_q] <= 1'b1;
							grant_q        <= ptr_q;
							state_q        <= S_DONE;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (match) begin
						taken_q[cmp_idx_s1] <= 1'b0;
						mask_q              <= mask_of(cmp_idx_s1);
					end else begin
						status_q <= STS_NOT_OWNER;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q.status       <= status_q;
						rsp_q.slot_out     <= 5'(grant_q);
						rsp_q.disable_mask <= mask_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/slot_table_checker.sv
// slot_table_checker: keeps its own slot table and search pointer, works out the
// result of every accepted request and compares each accepted result against it
// depends on osa_pkg; watches the req and rsp channels of the slot allocator

module slot_table_checker
	import osa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_item_t req_item,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_item_t rsp_item,
	output int        mismatches,
	output int        outstanding
);

	localparam int SLOTS       = 32;
	localparam int OWNER_LIMIT = 256;

	logic [8:0] slot_tag [SLOTS];
	logic [4:0] next_probe;
	rsp_item_t  expected_rsp [$];

	task automatic apply_request(input req_item_t r);
		rsp_item_t  e;
		logic       attached;
		logic       holds;
		logic       found;
		logic [4:0] idx;
		logic [8:0] tag;
		e        = '0;
		holds    = 1'b0;
		found    = 1'b0;
		attached = r.owner_attached && (int'(r.owner_id) < OWNER_LIMIT);
		tag      = {1'b1, r.owner_id};
		case (r.command)
			CMD_ASSIGN: begin
				if (!attached) begin
					e.status = STS_NOT_ATTACHED;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (slot_tag[i] == tag) holds = 1'b1;
					if (holds) begin
						e.status = STS_ALREADY_HOLDS;
					end else begin
						for (int i = 0; i < SLOTS && !found; i++) begin
							idx        = next_probe;
							next_probe = next_probe + 5'd1;
							if (!slot_tag[idx][8]) begin
								slot_tag[idx] = tag;
								e.slot_out    = idx;
								found         = 1'b1;
							end
						end
						if (!found) e.status = STS_ALL_BUSY;
					end
				end
			end
			CMD_RELEASE: begin
				if (!attached) begin
					e.status = STS_NOT_ATTACHED;
				end else if (int'(r.slot_in) >= SLOTS || slot_tag[r.slot_in] != tag) begin
					e.status = STS_NOT_OWNER;
				end else begin
					slot_tag[r.slot_in]       = '0;
					e.disable_mask[r.slot_in] = 1'b1;
				end
			end
			CMD_CLEANUP: begin
				if (attached) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_tag[i] == tag) begin
							slot_tag[i]       = '0;
							e.disable_mask[i] = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		expected_rsp.push_back(e);
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		rsp_item_t want;
		if (!arst_n) begin
			foreach (slot_tag[i]) slot_tag[i] = '0;
			next_probe = '0;
			expected_rsp.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: result expected none actual status %0h slot %0h mask %0h",
						$time, rsp_item.status, rsp_item.slot_out, rsp_item.disable_mask);
					mismatches++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("status", 32'(want.status), 32'(rsp_item.status));
					check_field("slot_out", 32'(want.slot_out), 32'(rsp_item.slot_out));
					check_field("disable_mask", want.disable_mask, rsp_item.disable_mask);
				end
			end
			if (req_valid && req_ready) apply_request(req_item);
			outstanding = expected_rsp.size();
		end
	end

endmodule

// File: tb/owner_tagged_slot_allocator_tb.sv
// owner_tagged_slot_allocator_tb: drives assign, release, cleanup and unused requests with
// random idling on both sides and gives the verdict from the checker's counts
// depends on osa_pkg, osa_chan_if, owner_tagged_slot_allocator and slot_table_checker

module owner_tagged_slot_allocator_tb
	import osa_pkg::*;
();

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic       clk;
	logic       arst_n;
	int         fail_total;
	int         waiting;
	int         items_sent;
	logic       quiet;
	logic       gap_mode;
	logic       long_hold_done;
	logic [5:0] held_slot [256];
	logic [7:0] pool [48];
	int         pool_n;
	req_item_t  in_flight [$];

	osa_chan_if #(.payload_t(req_item_t)) req_ch ();
	osa_chan_if #(.payload_t(rsp_item_t)) rsp_ch ();

	owner_tagged_slot_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	slot_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_ch.valid),
		.req_ready   (req_ch.ready),
		.req_item    (req_ch.payload),
		.rsp_valid   (rsp_ch.valid),
		.rsp_ready   (rsp_ch.ready),
		.rsp_item    (rsp_ch.payload),
		.mismatches  (fail_total),
		.outstanding (waiting)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#9_600_000;
		$display("owner_tagged_slot_allocator regression: fail");
		$finish;
	end

	// learn which slot each owner got, so releases can hit owned slots
	always @(posedge clk) begin : learn_grants
		req_item_t r;
		if (rsp_ch.valid && rsp_ch.ready && in_flight.size() != 0) begin
			r = in_flight.pop_front();
			if (rsp_ch.payload.status == STS_OK) begin
				if (r.command == CMD_ASSIGN && r.owner_attached)
					held_slot[r.owner_id] = {1'b1, rsp_ch.payload.slot_out};
				else if (r.command == CMD_RELEASE || r.command == CMD_CLEANUP)
					if (r.owner_attached) held_slot[r.owner_id] = '0;
			end
		end
		if (req_ch.valid && req_ch.ready) in_flight.push_back(req_ch.payload);
	end

	initial begin : result_side
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (quiet) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else if (!long_hold_done && items_sent >= 300) begin
				rsp_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold_done = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	task automatic send(input req_item_t it);
		req_ch.valid   <= 1'b1;
		req_ch.payload <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
		quiet = (items_sent >= 900);
		if (!quiet && gap_mode && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic make_pool(input int n);
		logic [7:0] base;
		logic [7:0] stride;
		base   = 8'($urandom);
		stride = 8'($urandom) | 8'd1;
		pool_n = n;
		for (int k = 0; k < n; k++) pool[k] = base + 8'(k) * stride;
	endtask

	function automatic req_item_t pool_item(input int assign_pct);
		req_item_t  it;
		int         roll;
		logic [7:0] who;
		who               = pool[$urandom_range(0, pool_n - 1)];
		roll              = $urandom_range(0, 99);
		it.owner_id       = who;
		it.owner_attached = ($urandom_range(0, 9) != 0);
		it.slot_in        = 5'($urandom);
		if (roll < assign_pct) begin
			it.command = CMD_ASSIGN;
		end else if (roll < assign_pct + (100 - assign_pct) * 2 / 3) begin
			it.command = CMD_RELEASE;
			if (held_slot[who][5] && $urandom_range(0, 3) != 0) it.slot_in = held_slot[who][4:0];
		end else if (roll < 97) begin
			it.command = CMD_CLEANUP;
		end else begin
			it.command = CMD_UNUSED;
		end
		return it;
	endfunction

	task automatic sweep_holders();
		for (int k = 0; k < 256; k++)
			if (held_slot[k][5]) send('{CMD_CLEANUP, 8'(k), 1'b1, 5'($urandom)});
	endtask

	initial begin : stimulus
		int len;
		int assign_pct;
		foreach (held_slot[k]) held_slot[k] = '0;
		items_sent     = 0;
		quiet          = 1'b0;
		gap_mode       = 1'b1;
		long_hold_done = 1'b0;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.payload <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send('{CMD_ASSIGN, 8'd0, 1'b0, 5'd0});
		send('{CMD_RELEASE, 8'd0, 1'b0, 5'd0});
		send('{CMD_CLEANUP, 8'd255, 1'b0, 5'd31});
		send('{CMD_UNUSED, 8'd255, 1'b1, 5'd31});
		send('{CMD_ASSIGN, 8'd255, 1'b1, 5'd31});
		send('{CMD_ASSIGN, 8'd255, 1'b1, 5'd0});
		send('{CMD_RELEASE, 8'd0, 1'b1, 5'd0});
		send('{CMD_RELEASE, 8'd255, 1'b1, 5'd31});
		send('{CMD_RELEASE, 8'd255, 1'b0, 5'd0});
		send('{CMD_ASSIGN, 8'd0, 1'b1, 5'd0});
		send('{CMD_RELEASE, 8'd255, 1'b1, 5'd0});
		send('{CMD_CLEANUP, 8'd0, 1'b1, 5'd0});
		send('{CMD_CLEANUP, 8'd0, 1'b1, 5'd0});

		// fill every slot, overflow it, then empty it again
		make_pool(36);
		for (int k = 0; k < 36; k++) send('{CMD_ASSIGN, pool[k], 1'b1, 5'($urandom)});
		send('{CMD_RELEASE, pool[3], 1'b1, 5'($urandom)});
		for (int k = 0; k < 36; k++) send('{CMD_CLEANUP, pool[k], 1'b1, 5'($urandom)});

		while (items_sent < 1050) begin
			case ($urandom_range(0, 5))
				0: make_pool(2);
				1: make_pool(6);
				2: make_pool(12);
				3: make_pool(24);
				4: make_pool(36);
				default: make_pool(44);
			endcase
			assign_pct = $urandom_range(30, 80);
			gap_mode   = ($urandom_range(0, 2) != 0);
			len        = $urandom_range(15, 60);
			repeat (len) begin
				if ($urandom_range(0, 11) == 0) send(req_item_t'(16'($urandom)));
				else send(pool_item(assign_pct));
			end
			if ($urandom_range(0, 1) == 0) sweep_holders();
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_total == 0 && waiting == 0) begin
			$display("owner_tagged_slot_allocator regression: pass");
		end else begin
			$display("owner_tagged_slot_allocator regression: fail");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/osa_pkg.sv
rtl/core/osa_chan_if.sv
rtl/core/owner_tagged_slot_allocator.sv
tb/slot_table_checker.sv
tb/owner_tagged_slot_allocator_tb.sv
